// ===== src/tbw_pkg.sv =====
// ----------------------------------------------------------------------------
// tbw_pkg - shared types and constants of the barycentric weight block
// Field widths, pipeline sizes, payload structs and the divider step.
// ----------------------------------------------------------------------------
package tbw_pkg;

  localparam int COORD_W          = 16;
  localparam int COORD_BITS       = 16;
  localparam int COORD_FRAC_BITS  = 4;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int OUT_W            = 24;
  localparam int CFG_W            = 21;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = CROSS_W;
  localparam int QW      = MAG_W + WEIGHT_FRAC_BITS;
  localparam int SW      = QW + 2;
  localparam int UW      = QW + 3;

  // magnitudes at or above this square past any legal limit
  localparam int SQ_BITS = (CFG_W + 1) / 2;

  localparam int MQ_DEPTH = 4;
  localparam int MQ_AW    = 2;
  localparam int OQ_DEPTH = 2;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] NEG_ONE =
    OUT_W'(-(64'sd1 <<< WEIGHT_FRAC_BITS));
  localparam logic signed [UW-1:0] ONE_U = UW'(64'sd1 <<< WEIGHT_FRAC_BITS);

  typedef struct packed {
    logic signed [COORD_W-1:0] corner_a_x;
    logic signed [COORD_W-1:0] corner_a_y;
    logic signed [COORD_W-1:0] corner_b_x;
    logic signed [COORD_W-1:0] corner_b_y;
    logic signed [COORD_W-1:0] corner_c_x;
    logic signed [COORD_W-1:0] corner_c_y;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] weight_u;
    logic signed [OUT_W-1:0] weight_v;
    logic signed [OUT_W-1:0] weight_w;
    logic                    degenerate;
  } out_t;

  typedef struct packed {
    logic vneg;
    logic wneg;
    logic degen;
  } side_t;

  typedef struct packed {
    logic [MAG_W-1:0] vm;
    logic [MAG_W-1:0] wm;
    logic [MAG_W-1:0] dm;
    side_t            sb;
  } mid_t;

  typedef struct packed {
    logic [QW-1:0] qv;
    logic [QW-1:0] qw;
    side_t         sb;
  } quo_t;

  // one restoring-division lane: partial remainder and dividend/quotient shifter
  typedef struct packed {
    logic [MAG_W-1:0] r;
    logic [QW-1:0]    x;
  } ds_t;

  function automatic ds_t div_step(input ds_t a, input logic [MAG_W-1:0] den);
    logic [MAG_W:0] t;
    logic           qb;
    ds_t            b;
    t = {a.r, a.x[QW-1]};
    if (t >= {1'b0, den}) begin
      b.r = MAG_W'(t - {1'b0, den});
      qb  = 1'b1;
    end else begin
      b.r = t[MAG_W-1:0];
      qb  = 1'b0;
    end
    b.x = {a.x[QW-2:0], qb};
    return b;
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [CROSS_W-1:0] x);
    return x[CROSS_W-1] ? MAG_W'(-x) : MAG_W'(x);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [UW-1:0] x);
    if (x > UW'(OUT_MAX)) begin
      return OUT_MAX;
    end else if (x < UW'(OUT_MIN)) begin
      return OUT_MIN;
    end
    return x[OUT_W-1:0];
  endfunction

endpackage

// ===== src/tbw_front.sv =====
// ----------------------------------------------------------------------------
// tbw_front - edge vectors, cross products and degeneracy test
// Four-stage pipeline that stalls as a whole while its last stage waits.
// ----------------------------------------------------------------------------
module tbw_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  tbw_pkg::in_t                in_data,
  input  logic [tbw_pkg::CFG_W-1:0]   min_den,
  output logic                        mq_push,
  input  logic                        mq_full,
  output tbw_pkg::mid_t               mq_data
);
  import tbw_pkg::*;

  logic en;
  logic vld_a_r, vld_b_r, vld_c_r, vld_d_r;

  logic signed [DIFF_W-1:0] e0x_r, e0y_r, e1x_r, e1y_r, e2x_r, e2y_r;
  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic [MAG_W-1:0]         dm_r, vm_r, wm_r;
  logic                     vneg_r, wneg_r;
  mid_t                     mid_r;

  logic signed [CROSS_W-1:0] d_c, nv_c, nw_c;
  logic [2*SQ_BITS-1:0]      sq_c;
  logic                      small_c, degen_c;

  function automatic logic signed [DIFF_W-1:0] sub(input logic signed [COORD_W-1:0] p,
                                                   input logic signed [COORD_W-1:0] q);
    return DIFF_W'($signed(p[COORD_BITS-1:0])) - DIFF_W'($signed(q[COORD_BITS-1:0]));
  endfunction

  assign en      = !(vld_d_r && mq_full);
  assign in_full = !en;
  assign mq_push = vld_d_r && !mq_full;
  assign mq_data = mid_r;

  always_comb begin
    d_c     = CROSS_W'(p0_r) - CROSS_W'(p1_r);
    nv_c    = CROSS_W'(p2_r) - CROSS_W'(p3_r);
    nw_c    = CROSS_W'(p4_r) - CROSS_W'(p5_r);
    small_c = (dm_r >> SQ_BITS) == '0;
    sq_c    = dm_r[SQ_BITS-1:0] * dm_r[SQ_BITS-1:0];
    degen_c = (dm_r == '0) || (small_c && (sq_c < (2*SQ_BITS)'(min_den)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_push;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
      vld_d_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0x_r <= sub(in_data.corner_b_x, in_data.corner_a_x);
      e0y_r <= sub(in_data.corner_b_y, in_data.corner_a_y);
      e1x_r <= sub(in_data.corner_c_x, in_data.corner_a_x);
      e1y_r <= sub(in_data.corner_c_y, in_data.corner_a_y);
      e2x_r <= sub(in_data.point_x, in_data.corner_a_x);
      e2y_r <= sub(in_data.point_y, in_data.corner_a_y);
      p0_r  <= PROD_W'(e0x_r) * PROD_W'(e1y_r);
      p1_r  <= PROD_W'(e0y_r) * PROD_W'(e1x_r);
      p2_r  <= PROD_W'(e2x_r) * PROD_W'(e1y_r);
      p3_r  <= PROD_W'(e2y_r) * PROD_W'(e1x_r);
      p4_r  <= PROD_W'(e0x_r) * PROD_W'(e2y_r);
      p5_r  <= PROD_W'(e0y_r) * PROD_W'(e2x_r);
      dm_r  <= mag(d_c);
      vm_r  <= mag(nv_c);
      wm_r  <= mag(nw_c);
      vneg_r <= nv_c[CROSS_W-1] != d_c[CROSS_W-1];
      wneg_r <= nw_c[CROSS_W-1] != d_c[CROSS_W-1];
      mid_r.vm       <= vm_r;
      mid_r.wm       <= wm_r;
      mid_r.dm       <= dm_r;
      mid_r.sb.vneg  <= vneg_r;
      mid_r.sb.wneg  <= wneg_r;
      mid_r.sb.degen <= degen_c;
    end
  end

endmodule

// ===== src/tbw_queue.sv =====
// ----------------------------------------------------------------------------
// tbw_queue - short queue between the front and back parts
// Register-based FIFO; the head entry is read directly.
// ----------------------------------------------------------------------------
module tbw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  tbw_pkg::mid_t wr_data,
  input  logic          pop,
  output logic          empty,
  output tbw_pkg::mid_t rd_data
);
  import tbw_pkg::*;

  mid_t             mem_r [MQ_DEPTH];
  logic [MQ_AW-1:0] wp_r, rp_r;
  logic [MQ_AW:0]   cnt_r;
  logic             do_push, do_pop;

  assign full    = cnt_r == (MQ_AW+1)'(MQ_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (MQ_AW+1)'(do_push) - (MQ_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_data;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (MQ_AW+1)'(MQ_DEPTH)) else $error("queue count past depth");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    MQ_AW'(wp_r - rp_r) == cnt_r[MQ_AW-1:0]) else $error("queue pointers off");

endmodule

// ===== src/tbw_divpipe.sv =====
// ----------------------------------------------------------------------------
// tbw_divpipe - two-lane pipelined restoring divider
// One quotient bit per stage for both weights against the shared divisor.
// ----------------------------------------------------------------------------
module tbw_divpipe (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  tbw_pkg::mid_t in_data,
  output logic          out_vld,
  output tbw_pkg::quo_t out_data
);
  import tbw_pkg::*;

  logic             vld_r [QW];
  ds_t              lv_r  [QW];
  ds_t              lw_r  [QW];
  logic [MAG_W-1:0] den_r [QW];
  side_t            sb_r  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    ds_t              src_v, src_w;
    logic [MAG_W-1:0] src_den;
    side_t            src_sb;
    logic             src_vld;

    if (s == 0) begin : g_first
      assign src_v   = {{MAG_W{1'b0}}, in_data.vm, {WEIGHT_FRAC_BITS{1'b0}}};
      assign src_w   = {{MAG_W{1'b0}}, in_data.wm, {WEIGHT_FRAC_BITS{1'b0}}};
      assign src_den = in_data.dm;
      assign src_sb  = in_data.sb;
      assign src_vld = in_vld;
    end else begin : g_next
      assign src_v   = lv_r[s-1];
      assign src_w   = lw_r[s-1];
      assign src_den = den_r[s-1];
      assign src_sb  = sb_r[s-1];
      assign src_vld = vld_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lv_r[s]  <= div_step(src_v, src_den);
        lw_r[s]  <= div_step(src_w, src_den);
        den_r[s] <= src_den;
        sb_r[s]  <= src_sb;
      end
    end
  end

  assign out_vld     = vld_r[QW-1];
  assign out_data.qv = lv_r[QW-1].x;
  assign out_data.qw = lw_r[QW-1].x;
  assign out_data.sb = sb_r[QW-1];

endmodule

// ===== src/tbw_back.sv =====
// ----------------------------------------------------------------------------
// tbw_back - division, weight assembly and result queue
// Drains the middle queue through the divider and saturates the weights.
// ----------------------------------------------------------------------------
module tbw_back (
  input  logic          clk,
  input  logic          rst_n,
  output logic          mq_pop,
  input  logic          mq_empty,
  input  tbw_pkg::mid_t mq_data,
  output logic          out_empty,
  input  logic          out_pop,
  output tbw_pkg::out_t out_data
);
  import tbw_pkg::*;

  logic en;
  logic dv_vld;
  quo_t dv_data;

  logic fin_vld_r;
  out_t fin_r;
  out_t res_c;

  out_t       oq_r [OQ_DEPTH];
  logic       oq_wp_r, oq_rp_r;
  logic [1:0] oq_cnt_r;
  logic       oq_full, oq_push, oq_pop;

  logic signed [SW-1:0] qv_s, qw_s, sv, sw;
  logic signed [UW-1:0] u_c;

  assign oq_full   = oq_cnt_r == 2'(OQ_DEPTH);
  assign out_empty = oq_cnt_r == '0;
  assign oq_push   = fin_vld_r && !oq_full;
  assign oq_pop    = out_pop && !out_empty;
  assign out_data  = oq_r[oq_rp_r];

  // advance the whole back pipeline unless its tail is blocked
  assign en     = !(fin_vld_r && oq_full);
  assign mq_pop = en && !mq_empty;

  tbw_divpipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (mq_pop),
    .in_data  (mq_data),
    .out_vld  (dv_vld),
    .out_data (dv_data)
  );

  always_comb begin
    qv_s = $signed(SW'(dv_data.qv));
    qw_s = $signed(SW'(dv_data.qw));
    sv   = dv_data.sb.vneg ? -qv_s : qv_s;
    sw   = dv_data.sb.wneg ? -qw_s : qw_s;
    u_c  = ONE_U - UW'(sv) - UW'(sw);
    if (dv_data.sb.degen) begin
      res_c.weight_u   = NEG_ONE;
      res_c.weight_v   = NEG_ONE;
      res_c.weight_w   = NEG_ONE;
      res_c.degenerate = 1'b1;
    end else begin
      res_c.weight_u   = sat(u_c);
      res_c.weight_v   = sat(UW'(sv));
      res_c.weight_w   = sat(UW'(sw));
      res_c.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) fin_r <= res_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) oq_wp_r <= !oq_wp_r;
      if (oq_pop)  oq_rp_r <= !oq_rp_r;
      oq_cnt_r <= oq_cnt_r + 2'(oq_push) - 2'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) oq_r[oq_wp_r] <= fin_r;
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= 2'(OQ_DEPTH)) else $error("result queue count past depth");
  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_vld_r && !en) |=> (fin_vld_r && $stable(fin_r)))
    else $error("blocked tail result changed");
  a_degen_w: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.degenerate) |->
      (out_data.weight_u == NEG_ONE && out_data.weight_v == NEG_ONE &&
       out_data.weight_w == NEG_ONE)) else $error("degenerate result not minus one");

endmodule

// ===== src/triangle_barycentric_weights.sv =====
// ----------------------------------------------------------------------------
// triangle_barycentric_weights - barycentric weights of a point in a triangle
// Fixed-point corners and point in, saturated Q7.16 weights and a degenerate
// flag out, one result per item.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                 Payload
//  -------  ------------------------  ----------------------------------------
//  in       in_push / in_full         in_data  : corners a, b, c and point
//  out      out_pop / out_empty       out_data : weights u, v, w, degenerate
//  cfg      cfg_we                    cfg_data : min_denominator
//
//  One item per cycle sustained while the result side keeps popping; the
//  divider retires one quotient bit per stage. The input transfer edge
//  loads the first of 4 front stages; an item then passes the other 3 front
//  stages, the middle queue, 51 divider stages, the assembly register and
//  the result queue before its result is ready.
//  Synchronous active-low reset empties both queues and clears all valid
//  bits; min_denominator returns to 1.
//  A stalled result side fills the result queue, then stalls the back part,
//  then the middle queue, and only then raises in_full.
// ----------------------------------------------------------------------------
module triangle_barycentric_weights (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  tbw_pkg::in_t              in_data,
  output logic                      out_empty,
  input  logic                      out_pop,
  output tbw_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [tbw_pkg::CFG_W-1:0] cfg_data
);
  import tbw_pkg::*;

  logic [CFG_W-1:0] min_den_r;

  // middle queue transfer signals
  logic mq_push, mq_full, mq_pop, mq_empty;
  mid_t mq_wr, mq_rd;

  // hold the degeneracy limit; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_den_r <= CFG_W'(1);
    end else if (cfg_we) begin
      min_den_r <= cfg_data;
    end
  end

  // front: edge vectors, cross products, classify degenerate triangles
  tbw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .min_den (min_den_r),
    .mq_push (mq_push),
    .mq_full (mq_full),
    .mq_data (mq_wr)
  );

  // decouple the front and back so each side stalls on its own
  tbw_queue u_mq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (mq_push),
    .full    (mq_full),
    .wr_data (mq_wr),
    .pop     (mq_pop),
    .empty   (mq_empty),
    .rd_data (mq_rd)
  );

  // back: divide, form u from the exact v and w, saturate, queue results
  tbw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mq_pop    (mq_pop),
    .mq_empty  (mq_empty),
    .mq_data   (mq_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - barycentric weight block check
// Drives corner/point sets through the queue-style input port, predicts the
// saturated Q7.16 weights and the degenerate flag with exact integer math,
// and checks every result transfer in order. Walks min_denominator through
// several settings, including both extremes, between idle phases.
// ----------------------------------------------------------------------------
class weight_scoreboard;
  tbw_pkg::out_t pending[$];
  logic [20:0]   min_den;
  int            mismatches;

  function new();
    min_den    = 21'd1;
    mismatches = 0;
  endfunction

  // Predict the weights for one corner/point set.
  function void note_input(tbw_pkg::in_t it);
    longint ax, ay, bx, by, cx, cy, px, py;
    longint d, nv, nw, dm, vm, wm, vq, wq, vi, wi, vf, wf, hi, lo, top, uu, vv, ww;
    bit degen, vneg, wneg;
    tbw_pkg::out_t r;
    ax = it.corner_a_x; ay = it.corner_a_y;
    bx = it.corner_b_x; by = it.corner_b_y;
    cx = it.corner_c_x; cy = it.corner_c_y;
    px = it.point_x;    py = it.point_y;
    d  = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    nv = (px - ax) * (cy - ay) - (py - ay) * (cx - ax);
    nw = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    dm = d < 0 ? -d : d;
    degen = (dm == 0) || (dm < (64'sd1 << 21) && dm * dm < longint'(min_den));
    if (degen) begin
      uu = -65536; vv = -65536; ww = -65536;
    end else begin
      vneg = (nv < 0) != (d < 0);
      wneg = (nw < 0) != (d < 0);
      vm = nv < 0 ? -nv : nv;
      wm = nw < 0 ? -nw : nw;
      vi = vm / dm; vf = ((vm % dm) << 16) / dm;
      wi = wm / dm; wf = ((wm % dm) << 16) / dm;
      vq = vi > (64'sd1 << 30) ? 64'sd1 << 47 : (vi << 16) | vf;
      wq = wi > (64'sd1 << 30) ? 64'sd1 << 47 : (wi << 16) | wf;
      vv = clamp(vneg ? -vq : vq);
      ww = clamp(wneg ? -wq : wq);
      hi  = (vneg ? -vi : vi) + (wneg ? -wi : wi);
      lo  = (vneg ? -vf : vf) + (wneg ? -wf : wf);
      top = 1 - hi;
      if (top > (64'sd1 << 30)) uu = 8388607;
      else if (top < -(64'sd1 << 30)) uu = -8388608;
      else uu = clamp(top * 65536 - lo);
    end
    r.weight_u   = uu[23:0];
    r.weight_v   = vv[23:0];
    r.weight_w   = ww[23:0];
    r.degenerate = degen;
    pending.push_back(r);
  endfunction

  function longint clamp(longint x);
    if (x > 8388607) return 8388607;
    if (x < -8388608) return -8388608;
    return x;
  endfunction

  // Compare one result transfer with the oldest prediction.
  function void check_result(tbw_pkg::out_t got);
    tbw_pkg::out_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending.pop_front();
    if (got.weight_u !== want.weight_u || got.weight_v !== want.weight_v ||
        got.weight_w !== want.weight_w || got.degenerate !== want.degenerate) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch u/v/w/deg exp %0d %0d %0d %b got %0d %0d %0d %b",
                 want.weight_u, want.weight_v, want.weight_w, want.degenerate,
                 got.weight_u, got.weight_v, got.weight_w, got.degenerate);
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_push = 1'b0;
  logic          in_full;
  tbw_pkg::in_t  in_data = '0;
  logic          out_empty;
  logic          out_pop = 1'b0;
  tbw_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic [tbw_pkg::CFG_W-1:0] cfg_data = '0;

  weight_scoreboard board = new();
  int  cycles = 0;

  triangle_barycentric_weights uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Watchdog: end the run if the limit is hit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[triangle_barycentric_weights] ERROR");
      $finish;
    end
  end

  // Most often no gap at all, otherwise mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: pop with random stalls; check each transfer at the edge.
  logic pop_stall_mode = 1'b0;
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) board.check_result(out_data);
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) pop_stall_mode = ~pop_stall_mode;
      if (pop_stall_mode) out_pop <= ($urandom_range(0, 9) == 0);
      else out_pop <= ($urandom_range(0, 3) != 0);
    end
  end

  // Send one set: drop push over the gap, hold it until the transfer, note it.
  task automatic send_item(tbw_pkg::in_t it);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    board.note_input(it);
  endtask

  // Stop sending, wait until every prediction is matched, let the pipe settle.
  task automatic drain();
    in_push <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [20:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.min_den = v;
  endtask

  function automatic tbw_pkg::in_t make_tri(int ax, int ay, int bx, int by,
                                            int cx, int cy, int px, int py);
    tbw_pkg::in_t t;
    t.corner_a_x = 16'(ax); t.corner_a_y = 16'(ay);
    t.corner_b_x = 16'(bx); t.corner_b_y = 16'(by);
    t.corner_c_x = 16'(cx); t.corner_c_y = 16'(cy);
    t.point_x = 16'(px);    t.point_y = 16'(py);
    return t;
  endfunction

  // Random set: mostly modest triangles, some full-range, some near-flat.
  function automatic tbw_pkg::in_t rand_item();
    tbw_pkg::in_t t;
    int k, s;
    k = $urandom_range(0, 9);
    if (k < 3) begin
      t = {$urandom(), $urandom(), $urandom(), $urandom()};
    end else begin
      s = (k < 6) ? 255 : ((k < 8) ? 4095 : 7);
      t.corner_a_x = 16'($urandom_range(0, 2 * s) - s);
      t.corner_a_y = 16'($urandom_range(0, 2 * s) - s);
      t.corner_b_x = 16'($urandom_range(0, 2 * s) - s);
      t.corner_b_y = 16'($urandom_range(0, 2 * s) - s);
      t.corner_c_x = 16'($urandom_range(0, 2 * s) - s);
      t.corner_c_y = 16'($urandom_range(0, 2 * s) - s);
      t.point_x = 16'($urandom_range(0, 4 * s) - 2 * s);
      t.point_y = 16'($urandom_range(0, 4 * s) - 2 * s);
      // collinear: c on the line through a and b
      if (k == 9) begin
        t.corner_c_x = 16'(2 * t.corner_b_x - t.corner_a_x);
        t.corner_c_y = 16'(2 * t.corner_b_y - t.corner_a_y);
      end
    end
    return t;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_item(rand_item());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets at the reset limit of 1.
    send_item(make_tri(0, 0, 16, 0, 0, 16, 4, 4));
    send_item(make_tri(0, 0, 16, 0, 0, 16, 0, 0));
    send_item(make_tri(0, 0, 16, 0, 0, 16, 16, 0));
    send_item(make_tri(0, 0, 16, 0, 0, 16, 0, 16));
    send_item(make_tri(0, 0, 16, 0, 0, 16, -16, -16));
    send_item(make_tri(0, 0, 1, 0, 0, 1, 32767, 32767));       // saturate high
    send_item(make_tri(0, 0, 1, 0, 0, 1, -32768, -32768));     // saturate low
    send_item(make_tri(0, 0, 1, 0, 0, 1, 32767, -32768));
    send_item(make_tri(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
    send_item(make_tri(32767, 32767, -32768, 32767, 32767, -32768, -1, 5));
    send_item(make_tri(0, 0, 16, 16, 32, 32, 5, 5));           // collinear
    send_item(make_tri(7, 7, 7, 7, 7, 7, 7, 7));               // single point
    send_item(make_tri(0, 0, 3, 0, 0, 3, 1, 1));
    send_item(make_tri(0, 0, 0, 16, 16, 0, 5, 3));             // clockwise
    send_item(make_tri(-32768, 32767, 32767, -32768, 0, 0, -32768, 32767));
    drain();

    // Limit 0: only a zero determinant is degenerate.
    write_limit(21'd0);
    send_item(make_tri(0, 0, 16, 16, 32, 32, 5, 5));
    send_item(make_tri(0, 0, 1, 0, 0, 1, 1, 0));
    random_phase(150);
    drain();

    // Largest limit: anything with |det| at or below 1448 is degenerate.
    write_limit(21'h1FFFFF);
    send_item(make_tri(0, 0, 32, 0, 0, 32, 3, 3));
    send_item(make_tri(0, 0, 31, 0, 0, 33, 3, 3));
    send_item(make_tri(0, 0, 1448, 0, 0, 1448, 9, 9));
    random_phase(150);
    drain();

    write_limit(21'd1048576);
    random_phase(150);
    // Hold the sender until every result has come back.
    in_push <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    random_phase(100);
    drain();

    write_limit(21'd1000);
    random_phase(150);
    drain();

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("[triangle_barycentric_weights] OK");
    end else begin
      $display("[triangle_barycentric_weights] ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/tbw_pkg.sv
src/tbw_front.sv
src/tbw_queue.sv
src/tbw_divpipe.sv
src/tbw_back.sv
src/triangle_barycentric_weights.sv
sim/testbench.sv
